[hdl/dda_pkg.sv]
// ----------------------------------------------------------------------------
// dda_pkg
// Shared constants, opcodes and control/status types of the DDA line
// rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

  // coordinate and fixed-point format
  localparam int unsigned COORD_BITS = 11;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned ACC_W      = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned INC_W      = FRAC_BITS + 2;
  localparam int unsigned DIFF_W     = COORD_BITS + 1;

  // increment divider: one quotient bit per cycle, magnitude up to 2**FRAC_BITS
  localparam int unsigned QUO_W      = FRAC_BITS + 1;
  localparam int unsigned DIV_STEPS  = QUO_W;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  // rounding constant, one half in fixed point
  localparam logic [ACC_W-1:0] HALF_ONE = ACC_W'(1) << (FRAC_BITS - 1);

  // input opcodes
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } dda_op_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load_line;  // start transaction: load endpoints, emit first point
    logic step;       // step transaction: advance accumulators, emit point
    logic div_step;   // one iteration of the increment division
    logic div_last;   // final iteration, capture the increments
  } dda_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic len_zero;   // presented line has zero length
    logic step_last;  // next step reaches the final endpoint
  } dda_sts_t;

endpackage

[hdl/dda_ctrl.sv]
// ----------------------------------------------------------------------------
// dda_ctrl
// Controller of the DDA line rasterizer: input/output handshake, line state
// and sequencing of the iterative increment division.
// ----------------------------------------------------------------------------
module dda_ctrl import dda_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     opcode_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dda_sts_t sts_i,
  output dda_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DIV    = 3'b010,
    S_ACTIVE = 3'b100
  } dda_state_e;

  dda_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             is_start;
  logic             is_step;
  logic             cnt_end;

  // accept while not dividing and the output register is free or draining
  assign in_ready_o = (state_q != S_DIV) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign is_start   = accept && (dda_op_e'(opcode_i) == OP_START);
  assign is_step    = accept && (dda_op_e'(opcode_i) == OP_STEP) && (state_q == S_ACTIVE);
  assign cnt_end    = (cnt_q == CNT_W'(DIV_STEPS - 1));

  // datapath commands
  always_comb begin
    cmd_o.load_line = is_start;
    cmd_o.step      = is_step;
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.div_last  = (state_q == S_DIV) && cnt_end;
  end

  // line state machine
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE, S_ACTIVE: begin
        if (is_start) begin
          cnt_d = '0;
          if (sts_i.len_zero) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_DIV;
          end
        end else if (is_step && sts_i.step_last) begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_end) begin
          state_d = S_ACTIVE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register valid flag
  always_comb begin
    if (is_start || is_step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hdl/dda_dpath.sv]
// ----------------------------------------------------------------------------
// dda_dpath
// Datapath of the DDA line rasterizer: endpoint differences, step count,
// restoring dividers for the increments, accumulators and output register.
// ----------------------------------------------------------------------------
module dda_dpath import dda_pkg::*; (
  input  logic                          clk_i,
  input  logic signed [COORD_BITS-1:0]  start_x_i,
  input  logic signed [COORD_BITS-1:0]  start_y_i,
  input  logic signed [COORD_BITS-1:0]  end_x_i,
  input  logic signed [COORD_BITS-1:0]  end_y_i,
  input  dda_cmd_t                      cmd_i,
  output dda_sts_t                      sts_o,
  output logic signed [COORD_BITS-1:0]  point_x_o,
  output logic signed [COORD_BITS-1:0]  point_y_o,
  output logic        [COORD_BITS-1:0]  point_index_o,
  output logic                          last_o
);

  localparam int unsigned REM_W = COORD_BITS + 1;

  // line geometry
  logic signed [DIFF_W-1:0]     dx, dy;
  logic        [DIFF_W-1:0]     dx_abs, dy_abs;
  logic        [COORD_BITS-1:0] mag_x, mag_y, len;

  // divider state
  logic [REM_W-1:0]     rem_x_q, rem_y_q, rem_x_d, rem_y_d;
  logic [QUO_W-1:0]     quo_x_q, quo_y_q, quo_x_d, quo_y_d;
  logic                 neg_x_q, neg_y_q;
  logic [REM_W-1:0]     len_ext;
  logic                 ge_x, ge_y;
  logic [REM_W-1:0]     sub_x, sub_y;

  // stepping state
  logic [COORD_BITS-1:0] len_q;
  logic [COORD_BITS-1:0] idx_q, idx_next;
  logic [INC_W-1:0]      inc_x_q, inc_y_q, inc_x_d, inc_y_d;
  logic [ACC_W-1:0]      acc_x_q, acc_y_q, acc_x_d, acc_y_d;
  logic [ACC_W-1:0]      rnd_x, rnd_y;

  // output register
  logic [COORD_BITS-1:0] px_q, py_q, pidx_q;
  logic                  last_q;

  // differences and step count
  assign dx     = DIFF_W'(end_x_i) - DIFF_W'(start_x_i);
  assign dy     = DIFF_W'(end_y_i) - DIFF_W'(start_y_i);
  assign dx_abs = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign dy_abs = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
  assign mag_x  = dx_abs[COORD_BITS-1:0];
  assign mag_y  = dy_abs[COORD_BITS-1:0];
  assign len    = (mag_x > mag_y) ? mag_x : mag_y;

  // one restoring division iteration per lane: compare, subtract, shift
  assign len_ext  = {1'b0, len_q};
  assign ge_x     = (rem_x_q >= len_ext);
  assign ge_y     = (rem_y_q >= len_ext);
  assign sub_x    = ge_x ? (rem_x_q - len_ext) : rem_x_q;
  assign sub_y    = ge_y ? (rem_y_q - len_ext) : rem_y_q;
  assign rem_x_d  = {sub_x[REM_W-2:0], 1'b0};
  assign rem_y_d  = {sub_y[REM_W-2:0], 1'b0};
  assign quo_x_d  = {quo_x_q[QUO_W-2:0], ge_x};
  assign quo_y_d  = {quo_y_q[QUO_W-2:0], ge_y};
  assign inc_x_d  = neg_x_q ? INC_W'(-{1'b0, quo_x_d}) : INC_W'({1'b0, quo_x_d});
  assign inc_y_d  = neg_y_q ? INC_W'(-{1'b0, quo_y_d}) : INC_W'({1'b0, quo_y_d});

  // accumulate and round half away from zero: bias is half, less one if negative
  assign acc_x_d  = acc_x_q + {{(ACC_W-INC_W){inc_x_q[INC_W-1]}}, inc_x_q};
  assign acc_y_d  = acc_y_q + {{(ACC_W-INC_W){inc_y_q[INC_W-1]}}, inc_y_q};
  assign rnd_x    = acc_x_d + HALF_ONE - ACC_W'(acc_x_d[ACC_W-1]);
  assign rnd_y    = acc_y_d + HALF_ONE - ACC_W'(acc_y_d[ACC_W-1]);
  assign idx_next = idx_q + COORD_BITS'(1);

  // status
  assign sts_o.len_zero  = (len == '0);
  assign sts_o.step_last = (idx_next == len_q);

  // line registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_line) begin
      len_q   <= len;
      idx_q   <= '0;
      rem_x_q <= {1'b0, mag_x};
      rem_y_q <= {1'b0, mag_y};
      quo_x_q <= '0;
      quo_y_q <= '0;
      neg_x_q <= dx[DIFF_W-1];
      neg_y_q <= dy[DIFF_W-1];
      acc_x_q <= {{(ACC_W-COORD_BITS-FRAC_BITS){start_x_i[COORD_BITS-1]}},
                  start_x_i, {FRAC_BITS{1'b0}}};
      acc_y_q <= {{(ACC_W-COORD_BITS-FRAC_BITS){start_y_i[COORD_BITS-1]}},
                  start_y_i, {FRAC_BITS{1'b0}}};
    end else if (cmd_i.div_step) begin
      rem_x_q <= rem_x_d;
      rem_y_q <= rem_y_d;
      quo_x_q <= quo_x_d;
      quo_y_q <= quo_y_d;
      if (cmd_i.div_last) begin
        inc_x_q <= inc_x_d;
        inc_y_q <= inc_y_d;
      end
    end else if (cmd_i.step) begin
      acc_x_q <= acc_x_d;
      acc_y_q <= acc_y_d;
      idx_q   <= idx_next;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_line) begin
      px_q   <= start_x_i;
      py_q   <= start_y_i;
      pidx_q <= '0;
      last_q <= sts_o.len_zero;
    end else if (cmd_i.step) begin
      px_q   <= rnd_x[FRAC_BITS +: COORD_BITS];
      py_q   <= rnd_y[FRAC_BITS +: COORD_BITS];
      pidx_q <= idx_next;
      last_q <= sts_o.step_last;
    end
  end

  assign point_x_o     = px_q;
  assign point_y_o     = py_q;
  assign point_index_o = pidx_q;
  assign last_o        = last_q;

endmodule

[hdl/dda_line_rasterizer.sv]
// Start transaction: point 0 is valid in the cycle after acceptance; then, for a nonzero
//   length, the increments are divided out one quotient bit per cycle, with no input taken.
// Step transaction: one point per cycle while the output is taken, valid in the cycle after
//   acceptance, limited by the single output register; step while idle gives no point.
// Reset (rst_ni low, asynchronous): no line loaded, output register empty.
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line generator: start loads two endpoints, each step emits the next
// rounded point along the line, flagging the final endpoint.
// ----------------------------------------------------------------------------
module dda_line_rasterizer import dda_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic signed [COORD_BITS-1:0]  start_x_i,
  input  logic signed [COORD_BITS-1:0]  start_y_i,
  input  logic signed [COORD_BITS-1:0]  end_x_i,
  input  logic signed [COORD_BITS-1:0]  end_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_BITS-1:0]  point_x_o,
  output logic signed [COORD_BITS-1:0]  point_y_o,
  output logic        [COORD_BITS-1:0]  point_index_o,
  output logic                          last_o
);

  dda_cmd_t cmd;
  dda_sts_t sts;

  // handshake and sequencing
  dda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic and output payload
  dda_dpath u_dpath (
    .clk_i         (clk_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .point_index_o (point_index_o),
    .last_o        (last_o)
  );

endmodule
